/* rtl/core/lspv_pkg.sv */
`timescale 1ns / 1ps

package lspv_pkg;

	localparam int FRAC_W   = 16;
	localparam int POS_W    = 40;
	localparam int LEN_W    = 24;
	localparam int SAMPLE_W = 16;
	localparam int VEL_W    = 13;
	localparam int STEP_W   = 32;
	localparam int DIV_W    = 24;
	localparam int QUO_W    = 16;
	localparam int CNT_W    = 5;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic [3:0] REG_ROOT    = 4'd0;
	localparam logic [3:0] REG_RATE    = 4'd1;
	localparam logic [3:0] REG_ATTACK  = 4'd2;
	localparam logic [3:0] REG_RELEASE = 4'd3;
	localparam logic [3:0] REG_LOOP_EN = 4'd4;
	localparam logic [3:0] REG_LSTART  = 4'd5;
	localparam logic [3:0] REG_LEND    = 4'd6;
	localparam logic [3:0] REG_SLEN    = 4'd7;

	localparam logic [16:0] ENV_ONE = 17'd65536;
	localparam logic [12:0] VEL_MAX = 13'd4096;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
		logic [DIV_W-1:0] rem_init;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] quot;
	} div_res_t;

	// 2^(k/12) in Q16
	function automatic logic [16:0] semitone_q16(input logic [3:0] k);
		logic [16:0] v;
		case (k)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd69433;
			4'd2:  v = 17'd73562;
			4'd3:  v = 17'd77936;
			4'd4:  v = 17'd82570;
			4'd5:  v = 17'd87480;
			4'd6:  v = 17'd92682;
			4'd7:  v = 17'd98193;
			4'd8:  v = 17'd104032;
			4'd9:  v = 17'd110218;
			4'd10: v = 17'd116772;
			4'd11: v = 17'd123715;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/lspv_ram.sv */
`timescale 1ns / 1ps

module lspv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/lspv_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; remainder must start below divisor
module lspv_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lspv_pkg::div_req_t  req,
	output lspv_pkg::div_res_t  res
);

	logic                          run_q;
	logic                          done_q;
	logic [lspv_pkg::CNT_W-1:0]    cnt_q;
	logic [lspv_pkg::DIV_W-1:0]    rem_q;
	logic [lspv_pkg::DIV_W-1:0]    dvd_q;
	logic [lspv_pkg::DIV_W-1:0]    den_q;
	logic [lspv_pkg::QUO_W-1:0]    quo_q;
	logic [lspv_pkg::DIV_W:0]      trial;
	logic                          ge;

	assign trial = {rem_q, dvd_q[lspv_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lspv_pkg::CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dividend;
			den_q <= req.divisor;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? lspv_pkg::DIV_W'(trial - {1'b0, den_q}) : trial[lspv_pkg::DIV_W-1:0];
			dvd_q <= {dvd_q[lspv_pkg::DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[lspv_pkg::QUO_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;
	assign res.quot = quo_q;

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> cnt_q != '0) else $error("divider running with zero count");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q)) else $error("divider done without a run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !req.start) else $error("divider restarted while running");

endmodule

/* rtl/core/looped_sample_playback_voice_unit.sv */
`timescale 1ns / 1ps

// One-voice sampler with linear interpolation and a looped region.
// Command channel: a word is taken when start is high and busy is low.
//   action load  : writes sample_value to the sample RAM, no result.
//   action start : latches a note; the phase step is then computed by a semitone
//                  table multiply, then an octave shift.
//   action tick  : one result on audio_sample/last, marked by result_valid for
//                  one cycle; on the way it passes two RAM reads, interpolation
//                  and two scale multiplies, the loop wrap through the serial
//                  divider (only inside the loop region), and the attack and
//                  release divisions when those ramps are in effect.
//   A tick while no note plays gives no result.
// Config channel: cfg_ready is always high; registers are to be written only
// idle, which the user must keep to, as the block itself does not check it.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the voice and loads register defaults; the sample RAM is not
// cleared and must be loaded before playback.
module looped_sample_playback_voice_unit #(
	parameter int SAMPLE_DEPTH = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          action,
	input  logic [15:0]         store_address,
	input  logic signed [15:0]  sample_value,
	input  logic [6:0]          note_number,
	input  logic [23:0]         note_length,
	input  logic [12:0]         velocity,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	output logic                result_valid,
	output logic signed [15:0]  audio_sample,
	output logic                last
);

	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int LCW = ($clog2(SAMPLE_DEPTH + 1) > 17) ? $clog2(SAMPLE_DEPTH + 1) : 17;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_STEP   = 12'b000000000010,
		ST_SHIFT  = 12'b000000000100,
		ST_MOD    = 12'b000000001000,
		ST_RDA    = 12'b000000010000,
		ST_RDB    = 12'b000000100000,
		ST_INTERP = 12'b000001000000,
		ST_ENVA   = 12'b000010000000,
		ST_ENVR   = 12'b000100000000,
		ST_SCALE  = 12'b001000000000,
		ST_ENVMUL = 12'b010000000000,
		ST_SPARE  = 12'b100000000000
	} state_t;

	state_t st_q;

	// configuration
	logic [6:0]  root_q;
	logic [19:0] rate_q;
	logic [23:0] atk_q, rel_q;
	logic        loop_en_q;
	logic [15:0] lstart_q, lend_q;
	logic [16:0] slen_q;

	// voice state
	logic [39:0] pos_q;
	logic [31:0] step_q;
	logic [23:0] idx_q, total_q, atk_use_q, rel_use_q;
	logic [12:0] vel_q;
	logic        active_q;

	// per-item work registers
	logic [4:0]          oct_q;
	logic [3:0]          sem_q;
	logic [36:0]         prod_q;
	logic                loop_q, zero_q, a_ok_q, b_ok_q, att_go_q;
	logic signed [15:0]  a_q, s_q;
	logic [16:0]         env_q;
	logic signed [29:0]  sv_q;

	logic                accept;
	logic                we;
	logic [AW-1:0]       raddr;
	logic [15:0]         rdata;
	lspv_pkg::div_req_t  dreq;
	lspv_pkg::div_res_t  dres;

	assign accept    = start && !busy;
	assign busy      = st_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign we        = accept && action == lspv_pkg::ACT_LOAD
		&& (32'(store_address) < 32'(SAMPLE_DEPTH));

	// tick setup
	logic [23:0]    ipos;
	logic [LCW-1:0] len_c;
	logic           loop_go, zero_go;
	assign ipos  = pos_q[39:16];
	assign len_c = (LCW'(slen_q) > LCW'(SAMPLE_DEPTH)) ? LCW'(SAMPLE_DEPTH) : LCW'(slen_q);
	assign loop_go = len_c != '0 && loop_en_q && lend_q >= lstart_q && ipos >= 24'(lstart_q);
	assign zero_go = len_c == '0
		|| (!loop_go && {8'b0, ipos} >= 32'(len_c) - 32'd1);

	// start setup: octave and semitone of note - root via reciprocal of 12
	logic [8:0]  dsum;
	logic [18:0] qm;
	logic [4:0]  qd;
	logic [8:0]  rd;
	assign dsum = 9'(note_number) + 9'd132 - 9'(root_q);
	assign qm   = 19'(dsum) * 19'd683;
	assign qd   = qm[17:13];
	assign rd   = dsum - 9'(qd) * 9'd12;

	// octave shift with saturation
	logic [47:0] st_wide;
	logic [31:0] step_new;
	always_comb begin
		if (oct_q >= 5'd11) begin
			st_wide = (48'(prod_q) << 4'(oct_q - 5'd11)) >> 16;
		end else begin
			st_wide = 48'(prod_q) >> 5'(5'd27 - oct_q);
		end
		step_new = (st_wide > 48'hFFFF_FFFF) ? '1 : st_wide[31:0];
	end

	// read index
	logic [24:0] ipos1, rd_idx, i1;
	logic        rd_ok;
	assign ipos1  = 25'(ipos) + 25'd1;
	assign i1     = (loop_q && ipos1 > 25'(lend_q)) ? 25'(lstart_q) : ipos1;
	assign rd_idx = (st_q == ST_RDB) ? i1 : 25'(ipos);
	assign rd_ok  = {7'b0, rd_idx} < 32'(SAMPLE_DEPTH);
	assign raddr  = AW'(rd_idx);

	// interpolation
	logic signed [15:0] b_val;
	logic signed [16:0] diff, s_full;
	logic signed [33:0] mulv, mulr;
	assign b_val  = b_ok_q ? signed'(rdata) : 16'sd0;
	assign diff   = 17'(b_val) - 17'(a_q);
	assign mulv   = diff * $signed({1'b0, pos_q[15:0]});
	assign mulr   = (mulv + 34'sd32768) >>> 16;
	assign s_full = 17'(a_q) + mulr[16:0];

	// envelope setup
	logic [23:0] rel_base, rel_k, rnum;
	logic        att_go, rel_go, rel_div;
	logic [16:0] env_a;
	assign att_go   = atk_use_q != '0 && idx_q < atk_use_q;
	assign rel_base = total_q - rel_use_q;
	assign rel_go   = rel_use_q != '0 && idx_q >= rel_base;
	assign rel_k    = idx_q - rel_base;
	assign rnum     = rel_use_q - rel_k;
	assign rel_div  = rel_go && rnum != rel_use_q;
	assign env_a    = att_go_q ? {1'b0, dres.quot} : lspv_pkg::ENV_ONE;

	logic enva_end;
	assign enva_end = !att_go_q || dres.done;

	// output scaling
	logic signed [47:0] t_full, y_full;
	logic signed [15:0] y_sat;
	logic [40:0]        pos_sum;
	logic               fin;
	assign t_full  = sv_q * $signed({1'b0, env_q});
	assign y_full  = (t_full + 48'sd134217728) >>> 28;
	assign y_sat   = (y_full > 48'sd32767) ? 16'sh7FFF
		: (y_full < -48'sd32768) ? 16'sh8000 : y_full[15:0];
	assign pos_sum = {1'b0, pos_q} + 41'(step_q);
	assign fin     = 25'(idx_q) + 25'd1 >= 25'(total_q);

	always_comb begin
		dreq = '0;
		case (st_q)
			ST_IDLE: begin
				if (accept && action == lspv_pkg::ACT_TICK && active_q && loop_go) begin
					dreq.start    = 1'b1;
					dreq.steps    = 5'd24;
					dreq.dividend = ipos - 24'(lstart_q);
					dreq.divisor  = 24'({1'b0, lend_q} - {1'b0, lstart_q} + 17'd1);
				end
			end
			ST_INTERP: begin
				if (att_go) begin
					dreq.start    = 1'b1;
					dreq.steps    = 5'd16;
					dreq.rem_init = idx_q;
					dreq.divisor  = atk_use_q;
				end
			end
			ST_ENVA: begin
				if (enva_end && rel_div) begin
					dreq.start    = 1'b1;
					dreq.steps    = 5'd16;
					dreq.rem_init = rnum;
					dreq.divisor  = rel_use_q;
				end
			end
			default: dreq = '0;
		endcase
	end

	lspv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.res    (dres)
	);

	lspv_ram #(
		.WIDTH (lspv_pkg::SAMPLE_W),
		.DEPTH (SAMPLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(store_address)),
		.wdata (sample_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q    <= 7'd60;
			rate_q    <= 20'd60211;
			atk_q     <= '0;
			rel_q     <= '0;
			loop_en_q <= 1'b0;
			lstart_q  <= '0;
			lend_q    <= '0;
			slen_q    <= 17'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lspv_pkg::REG_ROOT:    root_q    <= cfg_data[6:0];
				lspv_pkg::REG_RATE:    rate_q    <= cfg_data[19:0];
				lspv_pkg::REG_ATTACK:  atk_q     <= cfg_data;
				lspv_pkg::REG_RELEASE: rel_q     <= cfg_data;
				lspv_pkg::REG_LOOP_EN: loop_en_q <= cfg_data[0];
				lspv_pkg::REG_LSTART:  lstart_q  <= cfg_data[15:0];
				lspv_pkg::REG_LEND:    lend_q    <= cfg_data[15:0];
				lspv_pkg::REG_SLEN:    slen_q    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			active_q     <= 1'b0;
			pos_q        <= '0;
			step_q       <= '0;
			idx_q        <= '0;
			total_q      <= '0;
			vel_q        <= '0;
			atk_use_q    <= '0;
			rel_use_q    <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept && action == lspv_pkg::ACT_START) begin
						pos_q     <= '0;
						idx_q     <= '0;
						total_q   <= note_length;
						vel_q     <= (velocity > lspv_pkg::VEL_MAX) ? lspv_pkg::VEL_MAX : velocity;
						atk_use_q <= (atk_q > note_length) ? note_length : atk_q;
						rel_use_q <= (rel_q > note_length) ? note_length : rel_q;
						active_q  <= note_length != '0;
						st_q      <= ST_STEP;
					end else if (accept && action == lspv_pkg::ACT_TICK && active_q) begin
						st_q <= loop_go ? ST_MOD : ST_RDA;
					end
				end
				ST_STEP:  st_q <= ST_SHIFT;
				ST_SHIFT: begin
					step_q <= step_new;
					st_q   <= ST_IDLE;
				end
				ST_MOD: begin
					if (dres.done) begin
						pos_q <= {24'(lstart_q) + dres.rem, pos_q[15:0]};
						st_q  <= ST_RDA;
					end
				end
				ST_RDA:    st_q <= ST_RDB;
				ST_RDB:    st_q <= ST_INTERP;
				ST_INTERP: st_q <= ST_ENVA;
				ST_ENVA: begin
					if (enva_end) begin
						st_q <= rel_div ? ST_ENVR : ST_SCALE;
					end
				end
				ST_ENVR: begin
					if (dres.done) begin
						st_q <= ST_SCALE;
					end
				end
				ST_SCALE: st_q <= ST_ENVMUL;
				ST_ENVMUL: begin
					result_valid <= 1'b1;
					pos_q        <= pos_sum[40] ? '1 : pos_sum[39:0];
					idx_q        <= idx_q + 24'd1;
					if (fin) begin
						active_q <= 1'b0;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				oct_q  <= qd;
				sem_q  <= rd[3:0];
				loop_q <= loop_go;
				zero_q <= zero_go;
			end
			ST_STEP: prod_q <= 37'(rate_q) * 37'(lspv_pkg::semitone_q16(sem_q));
			ST_RDA:  a_ok_q <= rd_ok;
			ST_RDB: begin
				a_q    <= a_ok_q ? signed'(rdata) : 16'sd0;
				b_ok_q <= rd_ok;
			end
			ST_INTERP: begin
				s_q      <= zero_q ? 16'sd0 : s_full[15:0];
				att_go_q <= att_go;
			end
			ST_ENVA: begin
				if (enva_end) begin
					env_q <= env_a;
				end
			end
			ST_ENVR: begin
				if (dres.done && {1'b0, dres.quot} < env_q) begin
					env_q <= {1'b0, dres.quot};
				end
			end
			ST_SCALE: sv_q <= s_q * $signed({1'b0, vel_q});
			ST_ENVMUL: begin
				audio_sample <= y_sat;
				last         <= fin;
			end
			default: ;
		endcase
	end

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(st_q == ST_ENVMUL)) else $error("result without scale stage");
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while busy");
	a_active_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> (result_valid && last)
			|| $past(accept && action == lspv_pkg::ACT_START))
		else $error("voice stopped without last word or start");
	a_mod_loop: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_MOD |-> loop_q) else $error("loop wrap outside loop region");

endmodule
